### hdl/sorted_key_binary_search_defines.svh
// Assertion macros shared by the sorted key search RTL.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef SORTED_KEY_BINARY_SEARCH_DEFINES_SVH
`define SORTED_KEY_BINARY_SEARCH_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SKBS_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SKBS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/skbs_pkg.sv
// Shared types and constants for the sorted key search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package skbs_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam int TIME_W     = 48;
   localparam int STATION_W  = 32;
   localparam int KEY_W      = TIME_W + STATION_W;
   localparam int REQ_DATA_W = ((KEY_W + 7) / 8) * 8;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'd0,
      KIND_QUERY  = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_NOP    = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_ERROR     = 2'd2
   } status_type;

   typedef struct packed {
      logic equal;
      logic less;
   } cmp_result_type;

endpackage

`default_nettype wire

### hdl/skbs_table.sv
// Key table memory: one write port, one registered read port.
// Depends on skbs_pkg for the key width.
`default_nettype none

module skbs_table
   import skbs_pkg::*;
#(
   parameter int DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [KEY_W-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output logic      [KEY_W-1:0] rd_data
);

   logic [KEY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hdl/skbs_compare.sv
// Key comparator: signed time first, then unsigned station.
// Depends on skbs_pkg for key layout and the compare result struct.
`default_nettype none

module skbs_compare
   import skbs_pkg::*;
(
   input  wire logic [KEY_W-1:0] probe_key,
   input  wire logic [KEY_W-1:0] target_key,
   output cmp_result_type        result
);

   logic signed [TIME_W-1:0] probe_time;
   logic signed [TIME_W-1:0] target_time;
   logic [STATION_W-1:0]     probe_station;
   logic [STATION_W-1:0]     target_station;
   logic                     time_eq;

   assign probe_time     = probe_key[TIME_W-1:0];
   assign target_time    = target_key[TIME_W-1:0];
   assign probe_station  = probe_key[KEY_W-1:TIME_W];
   assign target_station = target_key[KEY_W-1:TIME_W];
   assign time_eq        = probe_time == target_time;

   assign result.equal = time_eq && (probe_station == target_station);
   assign result.less  = (probe_time < target_time) ||
                         (time_eq && (probe_station < target_station));

endmodule

`default_nettype wire

### hdl/skbs_seq.sv
// Sequencer: table load, query counting and bisection over the key table.
// Depends on skbs_pkg, skbs_table and skbs_compare, and the assertion macros.
`default_nettype none
`include "sorted_key_binary_search_defines.svh"

module skbs_seq
   import skbs_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [KEY_W-1:0]      req_key,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [CNT_W-1:0]      rsp_index,
   output logic      [STATUS_W-1:0]   rsp_status
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int QCNT_W = $clog2(TABLE_DEPTH + 2);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_COMPARE,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [QCNT_W-1:0] query_count_ff, query_count_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] res_index_ff, res_index_in;
   status_type       res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_index_ff, rsp_index_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic             req_accept;
   kind_type         kind;
   logic [QCNT_W-1:0] query_step;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] mid_calc;
   logic [CNT_W-1:0] mid_less1;
   logic             out_free;
   logic             wr_en;
   logic             rd_en;
   logic [KEY_W-1:0] rd_data;
   cmp_result_type   cmp;

   assign req_ready  = state_ff == S_IDLE;
   assign req_accept = req_valid && req_ready;
   assign kind       = kind_type'(req_kind);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign query_step = (query_count_ff <= QCNT_W'(TABLE_DEPTH)) ?
                       query_count_ff + QCNT_W'(1) : query_count_ff;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc  = mid_sum[CNT_W:1];
   assign mid_less1 = mid_calc - CNT_W'(1);

   assign wr_en = req_accept && (kind == KIND_APPEND) &&
                  (entry_count_ff < CNT_W'(TABLE_DEPTH));
   assign rd_en = state_ff == S_PROBE;

   skbs_table #(
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_count_ff[IDX_W-1:0]),
      .wr_data (req_key),
      .rd_en   (rd_en),
      .rd_addr (mid_less1[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   skbs_compare u_compare (
      .probe_key  (rd_data),
      .target_key (key_ff),
      .result     (cmp)
   );

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      query_count_in = query_count_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      key_in         = key_ff;
      res_index_in   = res_index_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_index_in   = rsp_index_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (kind)
                  KIND_APPEND: begin
                     if (wr_en) begin
                        entry_count_in = entry_count_ff + CNT_W'(1);
                     end
                  end
                  KIND_QUERY: begin
                     query_count_in = query_step;
                     key_in         = req_key;
                     lo_in          = CNT_W'(1);
                     hi_in          = entry_count_ff;
                     if ((entry_count_ff == '0) ||
                         (query_step > QCNT_W'(entry_count_ff))) begin
                        res_index_in  = '0;
                        res_status_in = STATUS_ERROR;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_PROBE;
                     end
                  end
                  KIND_CLEAR: begin
                     entry_count_in = '0;
                     query_count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PROBE: begin
            mid_in   = mid_calc;
            state_in = S_COMPARE;
         end
         S_COMPARE: begin
            if (cmp.equal) begin
               res_index_in  = mid_ff;
               res_status_in = STATUS_FOUND;
               state_in      = S_DONE;
            end else if (lo_ff == hi_ff) begin
               res_index_in  = '0;
               res_status_in = STATUS_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               if (cmp.less) begin
                  lo_in = (lo_ff == mid_ff) ? hi_ff : mid_ff;
               end else begin
                  hi_in = (hi_ff == mid_ff) ? lo_ff : mid_ff;
               end
               state_in = S_PROBE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = res_index_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         query_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         query_count_ff <= query_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      key_ff        <= key_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_status = rsp_status_ff;

   `SKBS_ASSERT_SAME(a_entry_bound, clock, reset, 1'b1,
      entry_count_ff <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
   `SKBS_ASSERT_SAME(a_bounds_order, clock, reset, state_ff == S_PROBE,
      (lo_ff != '0) && (lo_ff <= hi_ff) && (hi_ff <= entry_count_ff),
      "search bounds out of order")
   `SKBS_ASSERT_SAME(a_found_index, clock, reset, state_ff == S_DONE,
      (res_status_ff == STATUS_FOUND) == (res_index_ff != '0),
      "found status and index disagree")
   `SKBS_ASSERT_NEXT(a_empty_error, clock, reset,
      req_accept && (kind == KIND_QUERY) && (entry_count_ff == '0),
      (state_ff == S_DONE) && (res_status_ff == STATUS_ERROR),
      "query on empty table not flagged")

endmodule

`default_nettype wire

### hdl/sorted_key_binary_search.sv
// Sorted key search block, top level: stream ports around the sequencer.
// Depends on skbs_pkg and skbs_seq (which holds the table and comparator).
//
// Usage:
//   req channel: tuser carries the kind (append, query, clear, no-op),
//   tdata the key (signed Q32.16 time, then station id). Appends fill the
//   table in order; appends to a full table are dropped. Clear zeroes the
//   entry and query counts; stored words stay.
//   rsp channel: one word per query, tdata the 1-based match index (zero
//   when none), tuser the status (found, not found, error).
//   Append, clear and no-op complete in the idle state. A query rejected for
//   an empty table or an exhausted query count goes from idle to the done
//   state and then to the output register. A search runs P probes, each an
//   address and registered table read, then a compare and bound update in
//   the shared comparator; P is at most ceil(log2(entries)) + 2.
//   req_tready is low while a query is in progress. A stalled result word
//   holds in the output register; the next word accepted may still run
//   and waits for the register to drain before presenting its result.
//   Reset (synchronous) empties the table and drops any pending result.
`default_nettype none

module sorted_key_binary_search
   import skbs_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
   localparam int RSP_DATA_W = ((CNT_W + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [47:0] key_time, [79:48] key_station
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] kind
   input  wire logic [KIND_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [CNT_W-1:0] match_index, zero fill above
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic      [STATUS_W-1:0]   rsp_tuser
);

   logic [CNT_W-1:0] match_index;

   skbs_seq #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_key    (req_tdata[KEY_W-1:0]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_index  (match_index),
      .rsp_status (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(match_index);

endmodule

`default_nettype wire

### test/tb_sorted_key_binary_search.sv
// Testbench for sorted_key_binary_search: loads sorted key tables, queries them and
// checks every result word against a scoreboard that tracks the table and the bisection.
// Depends on skbs_pkg and the sorted_key_binary_search RTL.
`default_nettype none

module tb_sorted_key_binary_search;
   import skbs_pkg::*;

   localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int RSP_W       = ((CNT_W + 7) / 8) * 8;
   localparam int SET_MAX     = DEPTH + 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [TIME_W-1:0] T_MIN = 48'h8000_0000_0000;
   localparam logic [TIME_W-1:0] T_MAX = 48'h7FFF_FFFF_FFFF;

   class key_search_scoreboard;
      logic [TIME_W-1:0]    time_tab [DEPTH];
      logic [STATION_W-1:0] station_tab [DEPTH];
      int unsigned          entries;
      int unsigned          queries;
      logic [CNT_W-1:0]     index_q [$];
      status_type           status_q [$];
      int unsigned          mismatches;

      function new();
         entries    = 0;
         queries    = 0;
         mismatches = 0;
      endfunction

      static function bit key_below(logic [TIME_W-1:0] t_lhs, logic [STATION_W-1:0] s_lhs,
                                    logic [TIME_W-1:0] t_rhs, logic [STATION_W-1:0] s_rhs);
         return ($signed(t_lhs) < $signed(t_rhs)) || (t_lhs == t_rhs && s_lhs < s_rhs);
      endfunction

      function int unsigned bisect(logic [TIME_W-1:0] t, logic [STATION_W-1:0] s);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 1;
         hi = entries;
         for (int g = 0; g < 128; g++) begin
            mid = (lo + hi) / 2;
            if (time_tab[mid-1] == t && station_tab[mid-1] == s)
               return mid;
            if (lo == hi)
               return 0;
            if (key_below(time_tab[mid-1], station_tab[mid-1], t, s))
               lo = (lo == mid) ? hi : mid;
            else
               hi = (hi == mid) ? lo : mid;
         end
         return 0;
      endfunction

      function void note_word(kind_type k, logic [TIME_W-1:0] t, logic [STATION_W-1:0] s);
         int unsigned hit;
         case (k)
            KIND_APPEND: begin
               if (entries < DEPTH) begin
                  time_tab[entries]    = t;
                  station_tab[entries] = s;
                  entries++;
               end
            end
            KIND_CLEAR: begin
               entries = 0;
               queries = 0;
            end
            KIND_QUERY: begin
               if (queries <= DEPTH)
                  queries++;
               if (entries == 0 || queries > entries) begin
                  index_q.push_back('0);
                  status_q.push_back(STATUS_ERROR);
               end else begin
                  hit = bisect(t, s);
                  index_q.push_back(hit[CNT_W-1:0]);
                  status_q.push_back(hit != 0 ? STATUS_FOUND : STATUS_NOT_FOUND);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_word(logic [CNT_W-1:0] idx, logic [STATUS_W-1:0] st);
         if (index_q.size() == 0) begin
            $error("result word with no query outstanding: match_index %0d status %0d",
                   idx, st);
            mismatches++;
            return;
         end
         if (idx !== index_q[0]) begin
            $error("match_index: expected %0d, actual %0d", index_q[0], idx);
            mismatches++;
         end
         if (st !== status_q[0]) begin
            $error("status: expected %0d, actual %0d", status_q[0], st);
            mismatches++;
         end
         void'(index_q.pop_front());
         void'(status_q.pop_front());
      endfunction

      function int unsigned pending();
         return index_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   key_search_scoreboard  scoreboard;
   int unsigned           send_idle_pct = 0;
   int unsigned           recv_idle_pct = 0;
   int unsigned           items_sent = 0;
   int unsigned           cycle_count = 0;
   logic [TIME_W-1:0]     set_time [0:SET_MAX-1];
   logic [STATION_W-1:0]  set_station [0:SET_MAX-1];

   sorted_key_binary_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         scoreboard.check_word(rsp_tdata[CNT_W-1:0], rsp_tuser);
   end

   task automatic send_word(kind_type k, logic [TIME_W-1:0] t, logic [STATION_W-1:0] s);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s, t};
      req_tuser  <= k;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      scoreboard.note_word(k, t, s);
      if (k != KIND_NOP)
         items_sent++;
   endtask

   function automatic logic [TIME_W-1:0] pick_time(int unsigned mode, logic [TIME_W-1:0] base);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case (mode)
         0: return r[TIME_W-1:0];
         1: return base + $urandom_range(7);
         default: begin
            case ($urandom_range(3))
               0: return T_MIN;
               1: return T_MAX;
               2: return '1;
               default: return '0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [STATION_W-1:0] pick_station(int unsigned mode,
                                                          logic [STATION_W-1:0] base);
      case (mode)
         0: return $urandom;
         1: return base + $urandom_range(3);
         default: return $urandom_range(1) ? '1 : '0;
      endcase
   endfunction

   function automatic int unsigned pick_mode();
      int unsigned r;
      r = $urandom_range(99);
      return (r < 50) ? 0 : (r < 85) ? 1 : 2;
   endfunction

   task automatic build_set(int unsigned n, bit sorted);
      int unsigned       tmode;
      int unsigned       smode;
      logic [TIME_W-1:0] tbase;
      logic [STATION_W-1:0] sbase;
      logic [TIME_W-1:0] t;
      logic [STATION_W-1:0] s;
      int                j;
      tmode = pick_mode();
      smode = pick_mode();
      tbase = pick_time(0, '0);
      sbase = $urandom;
      for (int i = 0; i < n; i++) begin
         set_time[i]    = pick_time(tmode, tbase);
         set_station[i] = pick_station(smode, sbase);
      end
      if (sorted) begin
         for (int i = 1; i < n; i++) begin
            t = set_time[i];
            s = set_station[i];
            j = i;
            while (j > 0 && key_search_scoreboard::key_below(t, s, set_time[j-1],
                                                             set_station[j-1])) begin
               set_time[j]    = set_time[j-1];
               set_station[j] = set_station[j-1];
               j--;
            end
            set_time[j]    = t;
            set_station[j] = s;
         end
      end
   endtask

   task automatic send_query(int unsigned n);
      int unsigned          c;
      int unsigned          j;
      logic [TIME_W-1:0]    qt;
      logic [STATION_W-1:0] qs;
      c = $urandom_range(99);
      if (n > 0 && c < 80) begin
         j  = $urandom_range(n - 1);
         qt = set_time[j];
         qs = set_station[j];
         if (c >= 55) begin
            case ($urandom_range(3))
               0: qt = qt + 1;
               1: qt = qt - 1;
               2: qs = qs + 1;
               default: qs = qs - 1;
            endcase
         end
      end else begin
         qt = pick_time(pick_mode(), pick_time(0, '0));
         qs = pick_station(pick_mode(), $urandom);
      end
      send_word(KIND_QUERY, qt, qs);
   endtask

   task automatic run_table_set(int unsigned n, int unsigned nq, bit sorted);
      build_set(n, sorted);
      if ($urandom_range(9) != 0)
         send_word(KIND_CLEAR, pick_time(0, '0), $urandom);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0)
            send_word(KIND_NOP, pick_time(0, '0), $urandom);
         if ($urandom_range(19) == 0)
            send_query(i);
         send_word(KIND_APPEND, set_time[i], set_station[i]);
      end
      repeat (nq)
         send_query(n);
   endtask

   task automatic run_random(int unsigned target);
      int unsigned r;
      int unsigned n;
      while (items_sent < target) begin
         r = $urandom_range(99);
         n = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 16) : $urandom_range(17, 64);
         run_table_set(n, $urandom_range(0, n + 2), $urandom_range(99) >= 8);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_NOP;
      rsp_tready = 1'b0;
      scoreboard = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 65;

      // empty table, then a table spanning the extremes of both key fields
      send_word(KIND_QUERY, '0, '0);
      send_word(KIND_NOP, T_MAX, '1);
      send_word(KIND_CLEAR, '1, 32'h5555_5555);
      set_time[0] = T_MIN;  set_station[0] = '0;
      set_time[1] = T_MIN;  set_station[1] = '1;
      set_time[2] = '1;     set_station[2] = 32'hAAAA_AAAA;
      set_time[3] = '0;     set_station[3] = '0;
      set_time[4] = '0;     set_station[4] = 32'h0000_0001;
      set_time[5] = T_MAX;  set_station[5] = 32'h5555_5555;
      set_time[6] = T_MAX;  set_station[6] = '1;
      for (int i = 0; i < 7; i++)
         send_word(KIND_APPEND, set_time[i], set_station[i]);
      send_word(KIND_QUERY, set_time[6], set_station[6]);
      send_word(KIND_QUERY, set_time[0], set_station[0]);
      send_word(KIND_QUERY, set_time[4], set_station[4]);
      send_word(KIND_QUERY, '0, 32'h0000_0002);
      send_word(KIND_QUERY, set_time[2], set_station[2]);
      send_word(KIND_QUERY, set_time[1], set_station[1]);
      send_word(KIND_QUERY, set_time[5], set_station[5]);
      // one query more than entries
      send_word(KIND_QUERY, set_time[3], set_station[3]);
      send_word(KIND_CLEAR, '0, '0);
      send_word(KIND_QUERY, set_time[3], set_station[3]);

      run_random(160);
      send_idle_pct = 65;
      recv_idle_pct = 26;
      run_random(310);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(460);

      // fill past capacity so the last appends are dropped
      build_set(DEPTH + 3, 1'b1);
      send_word(KIND_CLEAR, '0, '0);
      for (int i = 0; i < DEPTH + 3; i++)
         send_word(KIND_APPEND, set_time[i], set_station[i]);
      repeat (40)
         send_query(DEPTH + 3);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (scoreboard.pending() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
+incdir+hdl
hdl/skbs_pkg.sv
hdl/skbs_table.sv
hdl/skbs_compare.sv
hdl/skbs_seq.sv
hdl/sorted_key_binary_search.sv
test/tb_sorted_key_binary_search.sv
